[rtl/sksg_pkg.sv]
// ----------------------------------------------------------------------------
// sksg_pkg
// Shared types and constants for the spline knot slope generator.
// ----------------------------------------------------------------------------
package sksg_pkg;

  localparam int unsigned MAX_KNOTS_DEF = 1024;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned IDX_W         = 10;
  localparam int unsigned Q_W           = 32;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_METHOD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MONOTONIC = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SEC_LOAD,
    ST_SEC_WAIT,
    ST_AK_N,
    ST_AK_MUL,
    ST_AK_DIV,
    ST_AK_WAIT,
    ST_BASE_DONE,
    ST_CL_LOAD,
    ST_CL_WAIT,
    ST_CL_EVAL,
    ST_EMIT,
    ST_OUT_WAIT
  } state_t;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic [63:0] num_mag;
    logic [63:0] den_mag;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo_mag;
  } div_rsp_t;

endpackage

[rtl/sksg_if.sv]
// ----------------------------------------------------------------------------
// sksg_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface sksg_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/spline_knot_slope_generator_core.sv]
// ----------------------------------------------------------------------------
// spline_knot_slope_generator_core
// Akima / Catmull-Rom knot slopes with optional Fritsch-Carlson clamp.
// ----------------------------------------------------------------------------
// Knots (x, y) enter one per request; each knot's slope leaves two knots
// later, and the knot flagged final flushes up to three pending slopes. Work
// runs one knot at a time through a single 64-bit radix-2 divider: a
// Catmull-Rom or end slope takes one division, an Akima slope four secants
// plus the weighting division unless the weight sum is under the threshold,
// and the monotone clamp up to two more secants. A single-knot list's slope
// needs no division. in_ready is low while a knot is in work or a slope waits
// in the output register.
module spline_knot_slope_generator_core #(
  parameter int unsigned MAX_KNOTS = sksg_pkg::MAX_KNOTS_DEF,
  parameter int unsigned FRAC_BITS = sksg_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [sksg_pkg::Q_W-1:0]     in_knot_x,
  input  logic signed [sksg_pkg::Q_W-1:0]     in_knot_y,
  input  logic                                in_final_knot,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sksg_pkg::IDX_W-1:0]          out_knot_index,
  output logic signed [sksg_pkg::Q_W-1:0]     out_slope,
  output logic                                out_last_slope,
  output logic                                out_divide_error,
  input  logic                                cfg_wr_en,
  input  logic [sksg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sksg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sksg_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_KNOTS + 2) + 1;
  localparam logic signed [63:0] QMAX = 64'sd2147483647;
  localparam logic signed [63:0] QMIN = -64'sd2147483648;

  // configuration
  logic        method_r, mono_r;
  logic [15:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= 1'b1;
      mono_r   <= 1'b0;
      thr_r    <= 16'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_METHOD:    method_r <= cfg_data[0];
        REG_MONOTONIC: mono_r   <= cfg_data[0];
        REG_THRESHOLD: thr_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // window, shift line of five knots
  logic signed [Q_W-1:0] wx_r [5];
  logic signed [Q_W-1:0] wy_r [5];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  state_t state_r, state_nxt;

  // job: knots cur..last to emit, with list length n and window top
  logic [CNT_W-1:0] n_r, n_nxt, cur_r, cur_nxt, last_r, last_nxt;
  logic [CNT_W-1:0] win_top_r, win_top_nxt;
  logic             flush_r, flush_nxt;

  // secant sequencing
  logic [2:0] sidx_r, sidx_nxt;       // which secant in the current list
  logic [2:0] snum_r, snum_nxt;       // how many secants
  logic signed [63:0] sec_r [4];
  logic signed [63:0] sec_nxt [4];
  logic err_r, err_nxt;
  logic signed [63:0] s_r, s_nxt, nsum_r, nsum_nxt, n0_r, n0_nxt, d_r, d_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic akima_r, akima_nxt;

  logic [IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic signed [Q_W-1:0] o_slope_r, o_slope_nxt;
  logic o_last_r, o_last_nxt, o_err_r, o_err_nxt, o_valid_r, o_valid_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  sksg_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // secant endpoints for current step: positions pa, pb = pa + span
  logic [CNT_W-1:0] pa, pb;
  logic [2:0] sa, sb;
  logic signed [63:0] dx, dy, dyq;
  logic signed [63:0] sec_res;
  logic signed [63:0] qs;

  function automatic logic [2:0] slot_of(input logic [CNT_W-1:0] p,
                                        input logic [CNT_W-1:0] t);
    logic [CNT_W-1:0] d;
    d = t - p;
    if (d > CNT_W'(4)) slot_of = 3'd0;
    else slot_of = 3'd4 - d[2:0];
  endfunction

  function automatic logic signed [63:0] abs64(input logic signed [63:0] v);
    abs64 = v[63] ? -v : v;
  endfunction

  // secant list: base secants then clamp secants
  always_comb begin
    pa = cur_r;
    pb = cur_r;
    if (state_r == ST_CL_LOAD || state_r == ST_CL_WAIT) begin
      if (sidx_r == 3'd0) begin pa = cur_r - CNT_W'(1); pb = cur_r; end
      else begin pa = cur_r; pb = cur_r + CNT_W'(1); end
    end else if (akima_r) begin
      pa = cur_r + CNT_W'(sidx_r) - CNT_W'(2);
      pb = pa + CNT_W'(1);
    end else if (cur_r == '0) begin
      pa = '0; pb = CNT_W'(1);
    end else if (cur_r == n_r - CNT_W'(1)) begin
      pa = n_r - CNT_W'(2); pb = n_r - CNT_W'(1);
    end else begin
      pa = cur_r - CNT_W'(1); pb = cur_r + CNT_W'(1);
    end
    sa  = slot_of(pa, win_top_r);
    sb  = slot_of(pb, win_top_r);
    dx  = 64'(wx_r[sb]) - 64'(wx_r[sa]);
    dy  = 64'(wy_r[sb]) - 64'(wy_r[sa]);
    dyq = dy <<< FRAC_BITS;
    qs  = (dy[63] ^ dx[63]) ? -$signed(drsp.quo_mag) : $signed(drsp.quo_mag);
    if (dx == 0) sec_res = dy > 0 ? QMAX : (dy < 0 ? QMIN : 64'sd0);
    else if (qs > QMAX) sec_res = QMAX;
    else if (qs < QMIN) sec_res = QMIN;
    else sec_res = qs;
  end

  logic signed [63:0] am, ap, delta, mag, avg, dabs;
  logic in_fire;
  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE) && !o_valid_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    n_nxt       = n_r;
    cur_nxt     = cur_r;
    last_nxt    = last_r;
    win_top_nxt = win_top_r;
    flush_nxt   = flush_r;
    sidx_nxt    = sidx_r;
    snum_nxt    = snum_r;
    sec_nxt     = sec_r;
    err_nxt     = err_r;
    s_nxt       = s_r;
    nsum_nxt    = nsum_r;
    n0_nxt      = n0_r;
    d_nxt       = d_r;
    prod_nxt    = prod_r;
    akima_nxt   = akima_r;
    o_idx_nxt   = o_idx_r;
    o_slope_nxt = o_slope_r;
    o_last_nxt  = o_last_r;
    o_err_nxt   = o_err_r;
    o_valid_nxt = o_valid_r && !out_ready;
    dreq        = '0;
    am = '0; ap = '0; delta = '0; mag = '0; avg = '0; dabs = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (cnt_r < CNT_W'(MAX_KNOTS)) begin
            cnt_nxt     = cnt_r + CNT_W'(1);
            win_top_nxt = cnt_r;
            if (!in_final_knot) begin
              if (cnt_r >= CNT_W'(2)) begin
                cur_nxt   = cnt_r - CNT_W'(2);
                last_nxt  = cnt_r - CNT_W'(2);
                n_nxt     = cnt_r + CNT_W'(2);
                flush_nxt = 1'b0;
                state_nxt = ST_SETUP;
              end
            end else begin
              cur_nxt   = cnt_r >= CNT_W'(2) ? cnt_r - CNT_W'(2) : '0;
              last_nxt  = cnt_r;
              n_nxt     = cnt_r + CNT_W'(1);
              flush_nxt = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_SETUP;
            end
          end else if (in_final_knot) begin
            win_top_nxt = cnt_r - CNT_W'(1);
            cur_nxt     = cnt_r >= CNT_W'(2) ? cnt_r - CNT_W'(2) : '0;
            last_nxt    = cnt_r - CNT_W'(1);
            n_nxt       = cnt_r;
            flush_nxt   = 1'b1;
            cnt_nxt     = '0;
            state_nxt   = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        err_nxt   = 1'b0;
        sidx_nxt  = '0;
        akima_nxt = method_r && cur_r >= CNT_W'(2) && cur_r + CNT_W'(3) <= n_r;
        snum_nxt  = akima_nxt ? 3'd4 : 3'd1;
        if (n_r <= CNT_W'(1)) begin
          s_nxt     = '0;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SEC_LOAD;
        end
      end
      ST_SEC_LOAD: begin
        dreq.start   = 1'b1;
        dreq.num_mag = abs64(dyq);
        dreq.den_mag = dx == 0 ? 64'd1 : abs64(dx);
        state_nxt    = ST_SEC_WAIT;
      end
      ST_SEC_WAIT: begin
        if (drsp.done) begin
          sec_nxt[sidx_r[1:0]] = sec_res;
          if (dx == 0) err_nxt = 1'b1;
          if (sidx_r + 3'd1 == snum_r) begin
            state_nxt = akima_r ? ST_AK_N : ST_BASE_DONE;
            if (!akima_r) s_nxt = sec_res;
          end else begin
            sidx_nxt  = sidx_r + 3'd1;
            state_nxt = ST_SEC_LOAD;
          end
        end
      end
      ST_AK_N: begin
        // sec: 0 mm2, 1 mm1, 2 m0, 3 mp1
        n0_nxt   = abs64(sec_r[1] - sec_r[0]);
        nsum_nxt = n0_nxt + abs64(sec_r[3] - sec_r[2]);
        d_nxt    = sec_r[2] - sec_r[1];
        avg      = sec_r[2] + sec_r[1];
        if (nsum_nxt == 0 || nsum_nxt < $signed({48'd0, thr_r})) begin
          s_nxt     = avg[63] ? -(abs64(avg) >>> 1) : (avg >>> 1);
          state_nxt = ST_BASE_DONE;
        end else begin
          state_nxt = ST_AK_MUL;
        end
      end
      ST_AK_MUL: begin
        // both factors under 2^33
        dabs      = abs64(d_r);
        prod_nxt  = 64'(n0_r[32:0]) * 64'(dabs[32:0]);
        state_nxt = ST_AK_DIV;
      end
      ST_AK_DIV: begin
        dreq.start   = 1'b1;
        dreq.num_mag = prod_r;
        dreq.den_mag = nsum_r;
        state_nxt    = ST_AK_WAIT;
      end
      ST_AK_WAIT: begin
        if (drsp.done) begin
          s_nxt = d_r[63] ? sec_r[1] - $signed(drsp.quo_mag)
                          : sec_r[1] + $signed(drsp.quo_mag);
          state_nxt = ST_BASE_DONE;
        end
      end
      ST_BASE_DONE: begin
        if (mono_r) begin
          sec_nxt[0] = s_r;
          sec_nxt[1] = s_r;
          if (cur_r >= CNT_W'(1)) begin
            sidx_nxt = 3'd0; state_nxt = ST_CL_LOAD;
          end else if (cur_r + CNT_W'(1) < n_r) begin
            sidx_nxt = 3'd1; state_nxt = ST_CL_LOAD;
          end else begin
            state_nxt = ST_CL_EVAL;
          end
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_CL_LOAD: begin
        dreq.start   = 1'b1;
        dreq.num_mag = abs64(dyq);
        dreq.den_mag = dx == 0 ? 64'd1 : abs64(dx);
        state_nxt    = ST_CL_WAIT;
      end
      ST_CL_WAIT: begin
        if (drsp.done) begin
          sec_nxt[sidx_r[1:0]] = sec_res;
          if (dx == 0) err_nxt = 1'b1;
          if (sidx_r == 3'd0 && cur_r + CNT_W'(1) < n_r) begin
            sidx_nxt = 3'd1; state_nxt = ST_CL_LOAD;
          end else begin
            state_nxt = ST_CL_EVAL;
          end
        end
      end
      ST_CL_EVAL: begin
        am    = abs64(sec_r[0]);
        ap    = abs64(sec_r[1]);
        delta = am < ap ? am : ap;
        if ((sec_r[0] < 0 && sec_r[1] > 0) || (sec_r[0] > 0 && sec_r[1] < 0))
          delta = '0;
        mag = abs64(s_r);
        if (mag > 3 * delta) s_nxt = s_r[63] ? -(3 * delta) : 3 * delta;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        o_valid_nxt = 1'b1;
        o_idx_nxt   = cur_r[IDX_W-1:0];
        o_slope_nxt = s_r[Q_W-1:0];
        o_last_nxt  = flush_r && (cur_r == last_r);
        o_err_nxt   = err_r;
        state_nxt   = ST_OUT_WAIT;
      end
      ST_OUT_WAIT: begin
        if (!o_valid_r || out_ready) begin
          if (cur_r == last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            cur_nxt   = cur_r + CNT_W'(1);
            state_nxt = ST_SETUP;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      o_valid_r <= 1'b0;
      for (int k = 0; k < 5; k++) begin
        wx_r[k] <= '0;
        wy_r[k] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      o_valid_r <= o_valid_nxt;
      if (in_fire && cnt_r < CNT_W'(MAX_KNOTS)) begin
        for (int k = 0; k < 4; k++) begin
          wx_r[k] <= wx_r[k+1];
          wy_r[k] <= wy_r[k+1];
        end
        wx_r[4] <= in_knot_x;
        wy_r[4] <= in_knot_y;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    cur_r     <= cur_nxt;
    last_r    <= last_nxt;
    win_top_r <= win_top_nxt;
    flush_r   <= flush_nxt;
    sidx_r    <= sidx_nxt;
    snum_r    <= snum_nxt;
    sec_r     <= sec_nxt;
    err_r     <= err_nxt;
    s_r       <= s_nxt;
    nsum_r    <= nsum_nxt;
    n0_r      <= n0_nxt;
    d_r       <= d_nxt;
    prod_r    <= prod_nxt;
    akima_r   <= akima_nxt;
    o_idx_r   <= o_idx_nxt;
    o_slope_r <= o_slope_nxt;
    o_last_r  <= o_last_nxt;
    o_err_r   <= o_err_nxt;
  end

  assign out_valid        = o_valid_r;
  assign out_knot_index   = o_idx_r;
  assign out_slope        = o_slope_r;
  assign out_last_slope   = o_last_r;
  assign out_divide_error = o_err_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |=> out_valid) else $error("slope not presented");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_KNOTS)) else $error("knot count overflow");

endmodule

[rtl/sksg_divider.sv]
// ----------------------------------------------------------------------------
// sksg_divider
// Radix-2 restoring divider on 64-bit magnitudes, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sksg_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  sksg_pkg::div_req_t req,
  output sksg_pkg::div_rsp_t rsp
);
  import sksg_pkg::*;

  logic [63:0] rem_r, rem_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[63]} - {1'b0, den_r};
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.num_mag;
      cnt_nxt  = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[64]) begin
        rem_nxt = trial[63:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[62:0], quo_r[63]};
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (req.start) den_r <= req.den_mag;
  end

  assign rsp.done    = done_r;
  assign rsp.quo_mag = quo_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("done while busy");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the spline knot slope generator. Knot lists go in
// through a valid/ready channel, a built-in predictor computes each slope and
// every returned slope is compared field by field. The run walks through
// several register settings and three sender/receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import sksg_pkg::*;

  localparam int unsigned KNOT_LIMIT = MAX_KNOTS_DEF;
  localparam longint      Q_HI       = 64'sd2147483647;
  localparam longint      Q_LO       = -64'sd2147483648;
  localparam int          DRAIN_CYC  = 600;

  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic                  fin;
  } knot_t;

  typedef struct packed {
    logic [IDX_W-1:0]      idx;
    logic signed [Q_W-1:0] slope;
    logic                  last;
    logic                  err;
  } slope_t;

  logic clk;
  logic rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sksg_if #(.payload_t(knot_t))  knot_ch ();
  sksg_if #(.payload_t(slope_t)) slope_ch ();

  spline_knot_slope_generator_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (knot_ch.valid),
    .in_ready        (knot_ch.ready),
    .in_knot_x       (knot_ch.data.x),
    .in_knot_y       (knot_ch.data.y),
    .in_final_knot   (knot_ch.data.fin),
    .out_valid       (slope_ch.valid),
    .out_ready       (slope_ch.ready),
    .out_knot_index  (slope_ch.data.idx),
    .out_slope       (slope_ch.data.slope),
    .out_last_slope  (slope_ch.data.last),
    .out_divide_error(slope_ch.data.err),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // predictor state
  bit          pm_method;
  bit          pm_mono;
  int unsigned pm_thresh;
  longint      win_x [5];
  longint      win_y [5];
  int unsigned stored;

  knot_t  pending_knots [$];
  slope_t expected_slopes [$];
  bit     knot_taken;
  int     idle_mode;
  int     errors;
  int     slopes_seen;
  int     lists_sent;
  int     knots_sent;

  initial begin
    clk = 1'b0;
  end
  always #10 clk = ~clk;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int unsigned slot_for(int unsigned p, int unsigned top);
    int unsigned d;
    d = top - p;
    if (d > 4) return 0;
    return 4 - d;
  endfunction

  function automatic longint secant_q(int unsigned pa, int unsigned pb, int unsigned top,
                                      inout bit err);
    longint dx, dy, q;
    dx = win_x[slot_for(pb, top)] - win_x[slot_for(pa, top)];
    dy = win_y[slot_for(pb, top)] - win_y[slot_for(pa, top)];
    if (dx == 0) begin
      err = 1'b1;
      return dy > 0 ? Q_HI : (dy < 0 ? Q_LO : 0);
    end
    q = (dy * (64'sd1 << FRAC_BITS_DEF)) / dx;
    if (q > Q_HI) q = Q_HI;
    if (q < Q_LO) q = Q_LO;
    return q;
  endfunction

  function automatic longint akima_slope(int unsigned i, int unsigned top, inout bit err);
    longint mm2, mm1, m0, mp1, n0, n1, wsum, d;
    longint unsigned q;
    mm2 = secant_q(i - 2, i - 1, top, err);
    mm1 = secant_q(i - 1, i, top, err);
    m0  = secant_q(i, i + 1, top, err);
    mp1 = secant_q(i + 1, i + 2, top, err);
    n1 = mp1 >= m0 ? mp1 - m0 : m0 - mp1;
    n0 = mm1 >= mm2 ? mm1 - mm2 : mm2 - mm1;
    wsum = n0 + n1;
    if (wsum == 0 || wsum < longint'(pm_thresh)) return (m0 + mm1) / 2;
    d = m0 - mm1;
    q = ($unsigned(n0) * $unsigned(d >= 0 ? d : -d)) / $unsigned(wsum);
    return d >= 0 ? mm1 + longint'(q) : mm1 - longint'(q);
  endfunction

  function automatic longint knot_slope(int unsigned i, int unsigned n, int unsigned top,
                                        inout bit err);
    longint s, m, p, am, ap, delta, mag;
    if (n <= 1) return 0;
    if (i == 0) s = secant_q(0, 1, top, err);
    else if (i == n - 1) s = secant_q(n - 2, n - 1, top, err);
    else if (pm_method && i >= 2 && i + 3 <= n) s = akima_slope(i, top, err);
    else s = secant_q(i - 1, i + 1, top, err);
    if (pm_mono) begin
      m = s;
      p = s;
      if (i >= 1) m = secant_q(i - 1, i, top, err);
      if (i + 1 < n) p = secant_q(i, i + 1, top, err);
      am = m >= 0 ? m : -m;
      ap = p >= 0 ? p : -p;
      delta = am < ap ? am : ap;
      if ((m < 0 && p > 0) || (m > 0 && p < 0)) delta = 0;
      mag = s >= 0 ? s : -s;
      if (mag > 3 * delta) s = s >= 0 ? 3 * delta : -3 * delta;
    end
    return s;
  endfunction

  function automatic void add_slope(int unsigned i, int unsigned n, int unsigned top, bit last);
    slope_t r;
    bit err;
    err = 1'b0;
    r.slope = 32'(knot_slope(i, n, top, err));
    r.idx   = IDX_W'(i);
    r.last  = last;
    r.err   = err;
    expected_slopes.push_back(r);
  endfunction

  function automatic void predict_knot(knot_t k);
    int unsigned top, first;
    int cnt;
    cnt = 0;
    if (stored < KNOT_LIMIT) begin
      for (int j = 0; j < 4; j++) begin
        win_x[j] = win_x[j+1];
        win_y[j] = win_y[j+1];
      end
      win_x[4] = longint'(k.x);
      win_y[4] = longint'(k.y);
      stored++;
      top = stored - 1;
      if (!k.fin) begin
        if (top >= 2) add_slope(top - 2, stored + 1, top, 1'b0);
        return;
      end
      first = top >= 2 ? top - 2 : 0;
    end else begin
      if (!k.fin) return;
      top = stored - 1;
      first = top >= 1 ? top - 1 : 0;
    end
    for (int unsigned i = first; i <= top && cnt < 3; i++) begin
      add_slope(i, stored, top, i == top);
      cnt++;
    end
    stored = 0;
  endfunction

  // accepted requests feed the predictor
  always @(posedge clk) begin
    if (rst_n && knot_ch.valid && knot_ch.ready) begin
      predict_knot(knot_ch.data);
      knot_taken = 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    slope_t want;
    if (rst_n && slope_ch.valid && slope_ch.ready) begin
      slopes_seen++;
      if (expected_slopes.size() == 0) begin
        report($sformatf("unexpected slope idx=%0d", slope_ch.data.idx));
      end else begin
        want = expected_slopes.pop_front();
        if (slope_ch.data.idx !== want.idx)
          report($sformatf("knot_index got %0d want %0d", slope_ch.data.idx, want.idx));
        if (slope_ch.data.slope !== want.slope)
          report($sformatf("slope idx=%0d got %h want %h", want.idx,
                           slope_ch.data.slope, want.slope));
        if (slope_ch.data.last !== want.last)
          report($sformatf("last_slope idx=%0d got %b want %b", want.idx,
                           slope_ch.data.last, want.last));
        if (slope_ch.data.err !== want.err)
          report($sformatf("divide_error idx=%0d got %b want %b", want.idx,
                           slope_ch.data.err, want.err));
      end
    end
  end

  // driver and receiver back-pressure
  always @(negedge clk) begin
    int send_idle, recv_idle;
    send_idle = idle_mode == 0 ? 31 : (idle_mode == 1 ? 79 : 0);
    recv_idle = idle_mode == 0 ? 79 : (idle_mode == 1 ? 31 : 0);
    if (rst_n) begin
      if (!knot_ch.valid || knot_taken) begin
        knot_taken = 1'b0;
        if (pending_knots.size() > 0 && $urandom_range(99) >= send_idle) begin
          knot_ch.data  <= pending_knots.pop_front();
          knot_ch.valid <= 1'b1;
        end else begin
          knot_ch.valid <= 1'b0;
        end
      end
      slope_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic push_knot(input longint x, input longint y, input bit fin);
    knot_t k;
    k.x   = 32'(x);
    k.y   = 32'(y);
    k.fin = fin;
    pending_knots.push_back(k);
    knots_sent++;
    if (fin) lists_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_METHOD:    pm_method = val[0];
      REG_MONOTONIC: pm_mono   = val[0];
      REG_THRESHOLD: pm_thresh = val & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int unsigned meth, input int unsigned mono,
                          input int unsigned thr);
    write_reg(REG_METHOD, meth);
    write_reg(REG_MONOTONIC, mono);
    write_reg(REG_THRESHOLD, thr);
  endtask

  // block can still be busy on a slope-less knot after the last result
  task automatic drain();
    while (pending_knots.size() > 0 || knot_ch.valid || expected_slopes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic random_list(input int unsigned len);
    longint x, y, stp;
    int unsigned style, r;
    style = $urandom_range(9);
    x = longint'($signed($urandom)) >>> 2;
    y = longint'($signed($urandom));
    if (style >= 3) y = y >>> 4;
    for (int unsigned j = 0; j < len; j++) begin
      push_knot(x, y, j == len - 1);
      r = $urandom_range(99);
      if (r < 8) stp = 0;
      else if (r < 12) stp = -longint'($urandom_range(32'h0010_0000));
      else if (r < 70) stp = $urandom_range(32'h0002_0000, 1);
      else stp = $urandom_range(32'h1000_0000, 1);
      x = x + stp;
      if (style < 3) y = longint'($signed($urandom));
      else if (style < 6) y = y + $urandom_range(32'h0004_0000);
      else y = y + longint'($urandom_range(32'h0008_0000)) - 64'sh0004_0000;
    end
  endtask

  task automatic random_phase(input int unsigned budget);
    int unsigned n0, len;
    n0 = knots_sent;
    while (knots_sent - n0 < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 11) : $urandom_range(10, 1);
      random_list(len);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    knot_ch.valid  = 1'b0;
    knot_ch.data   = '0;
    slope_ch.ready = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    knot_taken     = 1'b0;
    idle_mode      = 0;
    errors         = 0;
    slopes_seen    = 0;
    lists_sent     = 0;
    knots_sent     = 0;
    pm_method      = 1'b1;
    pm_mono        = 1'b0;
    pm_thresh      = 1;
    stored         = 0;
    foreach (win_x[j]) begin
      win_x[j] = 0;
      win_y[j] = 0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset settings, single knot, pair, equal x, extremes
    push_knot(64'sh0001_0000, 64'sh0005_0000, 1'b1);
    push_knot(0, 0, 1'b0);
    push_knot(64'sh0002_0000, -64'sh0003_0000, 1'b1);
    push_knot(64'sh0001_0000, 64'sh0001_0000, 1'b0);
    push_knot(64'sh0001_0000, 64'sh0004_0000, 1'b0);
    push_knot(64'sh0001_0000, -64'sh0004_0000, 1'b1);
    push_knot(Q_LO, Q_HI, 1'b0);
    push_knot(Q_LO + 1, Q_LO, 1'b0);
    push_knot(0, Q_HI, 1'b0);
    push_knot(1, 0, 1'b0);
    push_knot(Q_HI - 1, Q_LO, 1'b0);
    push_knot(Q_HI, Q_HI, 1'b1);
    for (int j = 0; j < 7; j++)
      push_knot(j * 64'sh0001_0000, (j % 3) * 64'sh0002_0000, j == 6);
    drain();
    set_regs(0, 1, 0);
    for (int j = 0; j < 6; j++)
      push_knot(j * 64'sh0001_0000, (j < 3 ? j : 5 - j) * 64'sh0003_0000, j == 5);
    drain();

    // random phases through settings and idling patterns
    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = ph / 2;
      case (ph)
        0: set_regs(1, 0, 0);
        1: set_regs(1, 1, 65535);
        2: set_regs(0, 0, 1);
        3: set_regs(1, 1, $urandom_range(65535));
        4: set_regs(1, 0, $urandom_range(4096));
        default: set_regs(0, 1, 65535);
      endcase
      random_phase(48);
      drain();
    end

    if (expected_slopes.size() != 0)
      report($sformatf("%0d slopes never arrived", expected_slopes.size()));
    $display("covered %0d knots in %0d lists, %0d slopes checked, %0d mismatches",
             knots_sent, lists_sent, slopes_seen, errors);
    $display("settings: both methods, clamp on/off, threshold 0..65535, equal x");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("FAILURE");
    $finish;
  end

endmodule
